### design/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
// No dependencies; used by mer_ctrl, mer_datapath and the top level.
package mer_pkg;

    localparam int AXIS_BITS = 10;
    localparam int OUT_BITS  = AXIS_BITS + 1;
    localparam int SQ_BITS   = 2 * AXIS_BITS;
    localparam int SUM_BITS  = 2 * AXIS_BITS + 1;
    localparam int PROD_BITS = 4 * AXIS_BITS;
    localparam int REM_BITS  = 2 * AXIS_BITS + 2;
    localparam int RT_BITS   = AXIS_BITS + 3;
    localparam int DEC_BITS  = 4 * AXIS_BITS + 8;
    localparam int CNT_BITS  = $clog2(4 * AXIS_BITS);

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] LAST_MIRROR = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_A,
        S_SQ_B,
        S_MUL_A2B,
        S_INIT1,
        S_DIV_LOAD,
        S_DIV,
        S_SQRT_LOAD,
        S_SQRT,
        S_STEP_MUL,
        S_STEP_ADD,
        S_STEP_SUB,
        S_R2_MUL,
        S_R2_INIT,
        S_CHECK,
        S_EMIT,
        S_EMIT_NONE
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REG1,
        PH_REG2,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SQ_A,
        DP_SQ_B,
        DP_MUL_A2B,
        DP_INIT1,
        DP_DIV_LOAD,
        DP_DIV_STEP,
        DP_SQRT_LOAD,
        DP_SQRT_STEP,
        DP_STEP_MUL,
        DP_STEP_ADD,
        DP_STEP_SUB,
        DP_R2_MUL,
        DP_R2_INIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       region2;
        logic       emit;
        logic [1:0] emit_k;
        logic       emit_point;
        logic       emit_last;
        logic       emit_done;
    } t_dp_cmd;

    typedef struct packed {
        logic x_le_bound;
        logic out_free;
    } t_dp_stat;

endpackage

### design/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
// Depends on mer_pkg, mer_ctrl and mer_datapath.

// Traces the first-quadrant arc of an origin-centred ellipse and sends every
// point as its four mirrored copies, in the order (x,y), (x,-y), (-x,y),
// (-x,-y), the last one flagged with last_of_step. A start transfer (cmd 0)
// loads the semi-axes (a zero axis counts as one) and yields the four copies
// of (0,b); each advance transfer (cmd 1) yields the next point. Region 1
// steps x up from (0,b) while x is at or below the boundary
// floor(a^2/sqrt(a^2+b^2)); then the arc restarts at (a,0) and region 2
// steps y up until x falls to the boundary. ellipse_done marks the four
// copies of the last point and every later advance. An advance with no
// ellipse loaded, or after completion, returns one result with has_point
// low. Items are processed one at a time; the output register lets the next
// item be taken while the last result is still waiting. A start loads the
// axes, squares a and b, forms a^2*b and the region 1 decision, then runs
// the serial divider (one quotient bit per step) and the serial square root
// (one root bit per step) for the boundary; a region step runs multiply, add
// and subtract on the shared multiplier (plus a check in region 2); the
// switch to region 2 runs its own multiply, the region 2 setup and the check.
// Each then loads its four copies into the output register as it has room,
// and the input is ready again in the same cycle as the last copy first
// shows there.
module midpoint_ellipse_rasterizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_a,
    input  logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_b,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_point_x,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_point_y,
    output logic                                o_has_point,
    output logic                                o_last_of_step,
    output logic                                o_ellipse_done
);

    mer_pkg::t_dp_cmd  dp_cmd;
    mer_pkg::t_dp_stat dp_stat;

    // sequencer: walks each transfer through setup, stepping and output
    mer_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // arithmetic, point state and the output register
    mer_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_semi_axis_a  (i_semi_axis_a),
        .i_semi_axis_b  (i_semi_axis_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_has_point    (o_has_point),
        .o_last_of_step (o_last_of_step),
        .o_ellipse_done (o_ellipse_done)
    );

    // a result without a point is always the whole answer to its transfer
    a_nopoint_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_point |-> o_last_of_step && o_point_x == '0
                                    && o_point_y == '0)
        else $error("empty result not last or not zero");

    // a start always runs the boundary setup, so input is not ready next cycle
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_cmd == mer_pkg::CMD_START |=> !o_ready)
        else $error("input ready right after a start");

    // the controller only loads the output register when there is room
    a_emit_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> dp_stat.out_free)
        else $error("result loaded over an untaken one");

    // the first mirrored copy of a point has non-negative coordinates
    a_first_mirror : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit && dp_cmd.emit_point && dp_cmd.emit_k == 2'd0
        |=> !o_point_x[mer_pkg::OUT_BITS-1] && !o_point_y[mer_pkg::OUT_BITS-1])
        else $error("first mirror copy negative");

endmodule

### design/mer_ctrl.sv
// Controller of the midpoint ellipse rasterizer: sequencing state machine,
// trace phase and step counters. Depends on mer_pkg.
module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_cmd,
    output logic              o_ready,
    input  mer_pkg::t_dp_stat i_stat,
    output mer_pkg::t_dp_cmd  o_cmd
);

    mer_pkg::t_state                r_state, n_state;
    mer_pkg::t_phase                r_phase, n_phase;
    logic [mer_pkg::CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [1:0]                     r_k, n_k;
    logic                           r_done_flag, n_done_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mer_pkg::S_IDLE;
            r_phase     <= mer_pkg::PH_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_done_flag <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_done_flag <= n_done_flag;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_done_flag = r_done_flag;
        o_ready     = (r_state == mer_pkg::S_IDLE);

        o_cmd.op         = mer_pkg::DP_NOP;
        o_cmd.region2    = (r_phase == mer_pkg::PH_REG2);
        o_cmd.emit       = 1'b0;
        o_cmd.emit_k     = r_k;
        o_cmd.emit_point = 1'b1;
        o_cmd.emit_last  = 1'b0;
        o_cmd.emit_done  = r_done_flag;

        unique case (r_state)
            mer_pkg::S_IDLE: begin
                n_k = '0;
                if (i_valid) begin
                    if (i_cmd == mer_pkg::CMD_START) begin
                        o_cmd.op    = mer_pkg::DP_LOAD;
                        n_phase     = mer_pkg::PH_REG1;
                        n_done_flag = 1'b0;
                        n_state     = mer_pkg::S_SQ_A;
                    end else begin
                        unique case (r_phase)
                            mer_pkg::PH_IDLE: begin
                                n_done_flag = 1'b0;
                                n_state     = mer_pkg::S_EMIT_NONE;
                            end
                            mer_pkg::PH_DONE: begin
                                n_done_flag = 1'b1;
                                n_state     = mer_pkg::S_EMIT_NONE;
                            end
                            mer_pkg::PH_REG1: begin
                                n_done_flag = 1'b0;
                                n_state     = i_stat.x_le_bound ? mer_pkg::S_STEP_MUL
                                                                : mer_pkg::S_R2_MUL;
                            end
                            default: begin
                                n_state = i_stat.x_le_bound ? mer_pkg::S_CHECK
                                                            : mer_pkg::S_STEP_MUL;
                            end
                        endcase
                    end
                end
            end
            mer_pkg::S_SQ_A: begin
                o_cmd.op = mer_pkg::DP_SQ_A;
                n_state  = mer_pkg::S_SQ_B;
            end
            mer_pkg::S_SQ_B: begin
                o_cmd.op = mer_pkg::DP_SQ_B;
                n_state  = mer_pkg::S_MUL_A2B;
            end
            mer_pkg::S_MUL_A2B: begin
                o_cmd.op = mer_pkg::DP_MUL_A2B;
                n_state  = mer_pkg::S_INIT1;
            end
            mer_pkg::S_INIT1: begin
                o_cmd.op = mer_pkg::DP_INIT1;
                n_state  = mer_pkg::S_DIV_LOAD;
            end
            mer_pkg::S_DIV_LOAD: begin
                o_cmd.op = mer_pkg::DP_DIV_LOAD;
                n_cnt    = mer_pkg::CNT_BITS'(mer_pkg::PROD_BITS - 1);
                n_state  = mer_pkg::S_DIV;
            end
            mer_pkg::S_DIV: begin
                o_cmd.op = mer_pkg::DP_DIV_STEP;
                if (r_cnt == '0) begin
                    n_state = mer_pkg::S_SQRT_LOAD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            mer_pkg::S_SQRT_LOAD: begin
                o_cmd.op = mer_pkg::DP_SQRT_LOAD;
                n_cnt    = mer_pkg::CNT_BITS'(mer_pkg::AXIS_BITS - 1);
                n_state  = mer_pkg::S_SQRT;
            end
            mer_pkg::S_SQRT: begin
                o_cmd.op = mer_pkg::DP_SQRT_STEP;
                if (r_cnt == '0) begin
                    n_state = mer_pkg::S_EMIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            mer_pkg::S_STEP_MUL: begin
                o_cmd.op = mer_pkg::DP_STEP_MUL;
                n_state  = mer_pkg::S_STEP_ADD;
            end
            mer_pkg::S_STEP_ADD: begin
                o_cmd.op = mer_pkg::DP_STEP_ADD;
                n_state  = mer_pkg::S_STEP_SUB;
            end
            mer_pkg::S_STEP_SUB: begin
                o_cmd.op = mer_pkg::DP_STEP_SUB;
                n_state  = (r_phase == mer_pkg::PH_REG2) ? mer_pkg::S_CHECK
                                                         : mer_pkg::S_EMIT;
            end
            mer_pkg::S_R2_MUL: begin
                o_cmd.op = mer_pkg::DP_R2_MUL;
                n_state  = mer_pkg::S_R2_INIT;
            end
            mer_pkg::S_R2_INIT: begin
                o_cmd.op = mer_pkg::DP_R2_INIT;
                n_phase  = mer_pkg::PH_REG2;
                n_state  = mer_pkg::S_CHECK;
            end
            mer_pkg::S_CHECK: begin
                // arc is complete once x has come back to the boundary
                if (i_stat.x_le_bound) begin
                    n_phase     = mer_pkg::PH_DONE;
                    n_done_flag = 1'b1;
                end else begin
                    n_done_flag = 1'b0;
                end
                n_state = mer_pkg::S_EMIT;
            end
            mer_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = (r_k == mer_pkg::LAST_MIRROR);
                    if (r_k == mer_pkg::LAST_MIRROR) begin
                        n_state = mer_pkg::S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            mer_pkg::S_EMIT_NONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_point = 1'b0;
                    o_cmd.emit_last  = 1'b1;
                    n_state          = mer_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mer_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/mer_datapath.sv
// Datapath of the midpoint ellipse rasterizer: shared multiplier, decision
// accumulator, serial divider and square root, output register. Uses mer_pkg.
module mer_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mer_pkg::t_dp_cmd                    i_cmd,
    output mer_pkg::t_dp_stat                   o_stat,
    input  logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_a,
    input  logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_b,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_point_x,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_point_y,
    output logic                                o_has_point,
    output logic                                o_last_of_step,
    output logic                                o_ellipse_done
);

    localparam int AW = mer_pkg::AXIS_BITS;
    localparam int SW = mer_pkg::SQ_BITS;
    localparam int PW = mer_pkg::PROD_BITS;
    localparam int DW = mer_pkg::DEC_BITS;
    localparam int RW = mer_pkg::REM_BITS;
    localparam int TW = mer_pkg::RT_BITS;
    localparam int OW = mer_pkg::OUT_BITS;

    logic [AW-1:0]        r_axis_a, n_axis_a;
    logic [AW-1:0]        r_axis_b, n_axis_b;
    logic [SW-1:0]        r_a2, n_a2;
    logic [SW-1:0]        r_b2, n_b2;
    logic [AW-1:0]        r_x, n_x;
    logic [AW-1:0]        r_y, n_y;
    logic signed [DW-1:0] r_dec, n_dec;
    logic [AW-1:0]        r_bound, n_bound;
    logic [PW-1:0]        r_prod, n_prod;
    logic [PW-1:0]        r_dq, n_dq;
    logic [RW-1:0]        r_rem, n_rem;
    logic [SW:0]          r_s, n_s;
    logic                 r_diag, n_diag;
    logic                 r_out_valid, n_out_valid;
    logic signed [OW-1:0] r_out_x, n_out_x;
    logic signed [OW-1:0] r_out_y, n_out_y;
    logic                 r_out_has, n_out_has;
    logic                 r_out_last, n_out_last;
    logic                 r_out_done, n_out_done;

    logic [SW-1:0]        m_a, m_b;
    logic [PW-1:0]        mul_p;
    logic [RW-1:0]        div_sh;
    logic [TW-1:0]        sq_sh, sq_trial;
    logic [OW-1:0]        px, py;

    function automatic logic signed [DW-1:0] to_dec(input logic [PW-1:0] v);
        return signed'({{(DW - PW){1'b0}}, v});
    endfunction

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            mer_pkg::DP_SQ_A: begin
                m_a = SW'(r_axis_a);
                m_b = SW'(r_axis_a);
            end
            mer_pkg::DP_SQ_B: begin
                m_a = SW'(r_axis_b);
                m_b = SW'(r_axis_b);
            end
            mer_pkg::DP_MUL_A2B: begin
                m_a = r_a2;
                m_b = SW'(r_axis_b);
            end
            mer_pkg::DP_INIT1: begin
                m_a = r_a2;
                m_b = r_a2;
            end
            mer_pkg::DP_STEP_MUL: begin
                m_a = i_cmd.region2 ? r_a2 : r_b2;
                m_b = i_cmd.region2 ? (SW'({r_y, 1'b0}) + SW'(3))
                                    : (SW'({r_x, 1'b0}) + SW'(3));
            end
            mer_pkg::DP_STEP_ADD: begin
                m_a = i_cmd.region2 ? r_b2 : r_a2;
                m_b = i_cmd.region2 ? (SW'(r_x) - SW'(1)) : (SW'(r_y) - SW'(1));
            end
            mer_pkg::DP_R2_MUL: begin
                m_a = r_b2;
                m_b = SW'(r_axis_a);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign mul_p    = m_a * m_b;
    assign div_sh   = {r_rem[RW-2:0], r_dq[PW-1]};
    assign sq_sh    = {r_rem[AW:0], r_dq[SW-1 -: 2]};
    assign sq_trial = {1'b0, r_bound, 2'b01};
    assign px       = {1'b0, r_x};
    assign py       = {1'b0, r_y};

    always_comb begin
        n_axis_a    = r_axis_a;
        n_axis_b    = r_axis_b;
        n_a2        = r_a2;
        n_b2        = r_b2;
        n_x         = r_x;
        n_y         = r_y;
        n_dec       = r_dec;
        n_bound     = r_bound;
        n_prod      = r_prod;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_s         = r_s;
        n_diag      = r_diag;

        case (i_cmd.op)
            mer_pkg::DP_LOAD: begin
                n_axis_a = (i_semi_axis_a == '0) ? AW'(1) : i_semi_axis_a;
                n_axis_b = (i_semi_axis_b == '0) ? AW'(1) : i_semi_axis_b;
                n_x      = '0;
                n_y      = (i_semi_axis_b == '0) ? AW'(1) : i_semi_axis_b;
            end
            mer_pkg::DP_SQ_A: begin
                n_prod = mul_p;
            end
            mer_pkg::DP_SQ_B: begin
                n_a2   = r_prod[SW-1:0];
                n_prod = mul_p;
            end
            mer_pkg::DP_MUL_A2B: begin
                n_b2   = r_prod[SW-1:0];
                n_prod = mul_p;
            end
            mer_pkg::DP_INIT1: begin
                // 4*(b2 - a2*b + a2/4)
                n_dec  = (to_dec(PW'(r_b2)) <<< 2) - (to_dec(r_prod) <<< 2)
                         + to_dec(PW'(r_a2));
                n_prod = mul_p;
            end
            mer_pkg::DP_DIV_LOAD: begin
                n_dq  = r_prod;
                n_rem = '0;
                n_s   = {1'b0, r_a2} + {1'b0, r_b2};
            end
            mer_pkg::DP_DIV_STEP: begin
                if (div_sh >= RW'(r_s)) begin
                    n_rem = div_sh - RW'(r_s);
                    n_dq  = {r_dq[PW-2:0], 1'b1};
                end else begin
                    n_rem = div_sh;
                    n_dq  = {r_dq[PW-2:0], 1'b0};
                end
            end
            mer_pkg::DP_SQRT_LOAD: begin
                n_rem   = '0;
                n_bound = '0;
            end
            mer_pkg::DP_SQRT_STEP: begin
                n_dq = {r_dq[PW-3:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    n_rem   = RW'(sq_sh - sq_trial);
                    n_bound = {r_bound[AW-2:0], 1'b1};
                end else begin
                    n_rem   = RW'(sq_sh);
                    n_bound = {r_bound[AW-2:0], 1'b0};
                end
            end
            mer_pkg::DP_STEP_MUL: begin
                n_prod = mul_p;
                // region 1 holds y once it reaches the axis
                n_diag = (r_dec >= 0) && (i_cmd.region2 || (r_y != '0));
            end
            mer_pkg::DP_STEP_ADD: begin
                n_dec  = r_dec + (to_dec(r_prod) <<< 2);
                n_prod = mul_p;
            end
            mer_pkg::DP_STEP_SUB: begin
                if (r_diag) begin
                    n_dec = r_dec - (to_dec(r_prod) <<< 3);
                end
                if (i_cmd.region2) begin
                    if (r_diag) begin
                        n_x = r_x - 1'b1;
                    end
                    if (r_y != '1) begin
                        n_y = r_y + 1'b1;
                    end
                end else begin
                    if (r_diag) begin
                        n_y = r_y - 1'b1;
                    end
                    n_x = r_x + 1'b1;
                end
            end
            mer_pkg::DP_R2_MUL: begin
                n_prod = mul_p;
            end
            mer_pkg::DP_R2_INIT: begin
                // 4*(a2 - b2*a + b2/4)
                n_x   = r_axis_a;
                n_y   = '0;
                n_dec = (to_dec(PW'(r_a2)) <<< 2) - (to_dec(r_prod) <<< 2)
                        + to_dec(PW'(r_b2));
            end
            default: begin
                n_diag = r_diag;
            end
        endcase
    end

    // output register; mirror k: bit 1 negates x, bit 0 negates y
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_has   = i_cmd.emit_point;
            n_out_last  = i_cmd.emit_last;
            n_out_done  = i_cmd.emit_done;
            if (i_cmd.emit_point) begin
                n_out_x = signed'(i_cmd.emit_k[1] ? ((~px) + OW'(1)) : px);
                n_out_y = signed'(i_cmd.emit_k[0] ? ((~py) + OW'(1)) : py);
            end else begin
                n_out_x = '0;
                n_out_y = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis_a   <= n_axis_a;
        r_axis_b   <= n_axis_b;
        r_a2       <= n_a2;
        r_b2       <= n_b2;
        r_x        <= n_x;
        r_y        <= n_y;
        r_dec      <= n_dec;
        r_bound    <= n_bound;
        r_prod     <= n_prod;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_s        <= n_s;
        r_diag     <= n_diag;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign o_stat.x_le_bound = (r_x <= r_bound);
    assign o_stat.out_free   = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_point_x      = r_out_x;
    assign o_point_y      = r_out_y;
    assign o_has_point    = r_out_has;
    assign o_last_of_step = r_out_last;
    assign o_ellipse_done = r_out_done;

endmodule

### verif/midpoint_ellipse_rasterizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_ellipse_rasterizer: directed and random
// ellipse traces, an in-bench arc predictor and an in-order point scoreboard.
// Depends on mer_pkg and the midpoint_ellipse_rasterizer RTL.
module midpoint_ellipse_rasterizer_tb;

    // Run length guard for the whole simulation.
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_ITEMS = 350;
    localparam int unsigned QUIET_TAIL   = 50;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam longint      DEC_LIMIT    = 64'sh4000_0000_0000_0000;

    // One mirrored point as the block should emit it.
    typedef struct {
        logic signed [mer_pkg::OUT_BITS-1:0] x;
        logic signed [mer_pkg::OUT_BITS-1:0] y;
        logic                                has_point;
        logic                                last;
        logic                                done;
    } t_mirror_result;

    // Tracks the arc being traced and the queue of mirrored points still owed.
    class arc_scoreboard;
        logic [mer_pkg::AXIS_BITS-1:0] axis_a;
        logic [mer_pkg::AXIS_BITS-1:0] cur_x;
        logic [mer_pkg::AXIS_BITS-1:0] cur_y;
        logic [mer_pkg::AXIS_BITS-1:0] bound;
        logic [mer_pkg::SQ_BITS-1:0]   a_sq;
        logic [mer_pkg::SQ_BITS-1:0]   b_sq;
        longint                        decision;
        mer_pkg::t_phase               phase;
        t_mirror_result                expected_points[$];
        int unsigned                   errors;

        function new();
            axis_a   = '0;
            cur_x    = '0;
            cur_y    = '0;
            bound    = '0;
            a_sq     = '0;
            b_sq     = '0;
            decision = 0;
            phase    = mer_pkg::PH_IDLE;
            errors   = 0;
        endfunction

        function int unsigned pending();
            return expected_points.size();
        endfunction

        function bit arc_closed();
            return phase == mer_pkg::PH_DONE;
        endfunction

        // Decision value is clamped to +-2^62.
        function void add_saturated(longint inc);
            longint sum;
            sum = decision + inc;
            if (sum > DEC_LIMIT)
                sum = DEC_LIMIT;
            else if (sum < -DEC_LIMIT)
                sum = -DEC_LIMIT;
            decision = sum;
        endfunction

        // Four copies of the current point: (x,y) (x,-y) (-x,y) (-x,-y).
        function void push_mirrors(bit done);
            t_mirror_result                      r;
            logic signed [mer_pkg::OUT_BITS-1:0] px;
            logic signed [mer_pkg::OUT_BITS-1:0] py;
            px = $signed({1'b0, cur_x});
            py = $signed({1'b0, cur_y});
            for (int k = 0; k < 4; k++) begin
                r.x         = (k < 2) ? px : -px;
                r.y         = (k[0] == 1'b0) ? py : -py;
                r.has_point = 1'b1;
                r.last      = (k == mer_pkg::LAST_MIRROR);
                r.done      = done;
                expected_points.push_back(r);
            end
        endfunction

        // Advance with nothing to show: a single flagged empty result.
        function void push_empty(bit done);
            t_mirror_result r;
            r.x         = '0;
            r.y         = '0;
            r.has_point = 1'b0;
            r.last      = 1'b1;
            r.done      = done;
            expected_points.push_back(r);
        endfunction

        function void note_input(logic cmd, logic [mer_pkg::AXIS_BITS-1:0] in_a,
                                 logic [mer_pkg::AXIS_BITS-1:0] in_b);
            longint av;
            longint bv;
            longint q;
            longint t;
            longint root;
            longint a2;
            longint b2;
            longint xs;
            longint ys;
            longint inc;
            if (cmd == mer_pkg::CMD_START) begin
                // zero axis counts as one
                av = (in_a == '0) ? 64'sd1 : longint'(in_a);
                bv = (in_b == '0) ? 64'sd1 : longint'(in_b);
                axis_a = mer_pkg::AXIS_BITS'(av);
                a_sq   = mer_pkg::SQ_BITS'(av * av);
                b_sq   = mer_pkg::SQ_BITS'(bv * bv);
                a2     = longint'(a_sq);
                b2     = longint'(b_sq);
                // boundary = floor(sqrt(floor(a^4 / (a^2 + b^2))))
                q    = (a2 * a2) / (a2 + b2);
                root = 0;
                for (int i = 15; i >= 0; i--) begin
                    t = root | (64'sd1 << i);
                    if (t * t <= q)
                        root = t;
                end
                bound    = mer_pkg::AXIS_BITS'(root);
                cur_x    = '0;
                cur_y    = mer_pkg::AXIS_BITS'(bv);
                decision = 4 * b2 - 4 * a2 * bv + a2;
                phase    = mer_pkg::PH_REG1;
                push_mirrors(1'b0);
                return;
            end
            a2 = longint'(a_sq);
            b2 = longint'(b_sq);
            xs = longint'(cur_x);
            ys = longint'(cur_y);
            case (phase)
                mer_pkg::PH_REG1: begin
                    if (cur_x <= bound) begin
                        inc = 4 * b2 * (2 * xs + 3);
                        // no diagonal move once y has reached the axis
                        if (decision >= 0 && cur_y != '0) begin
                            inc += 4 * a2 * (2 - 2 * ys);
                            cur_y--;
                        end
                        add_saturated(inc);
                        cur_x++;
                        push_mirrors(1'b0);
                    end else begin
                        // region 2 restarts from (a,0), which is emitted
                        cur_x    = axis_a;
                        cur_y    = '0;
                        xs       = longint'(axis_a);
                        decision = 4 * a2 - 4 * b2 * xs + b2;
                        phase    = mer_pkg::PH_REG2;
                        if (cur_x <= bound)
                            phase = mer_pkg::PH_DONE;
                        push_mirrors(phase == mer_pkg::PH_DONE);
                    end
                end
                mer_pkg::PH_REG2: begin
                    if (cur_x > bound) begin
                        inc = 4 * a2 * (2 * ys + 3);
                        if (decision >= 0) begin
                            inc += 4 * b2 * (2 - 2 * xs);
                            cur_x--;
                        end
                        add_saturated(inc);
                        // y sticks at its top value
                        if (cur_y != '1)
                            cur_y++;
                    end
                    if (cur_x <= bound)
                        phase = mer_pkg::PH_DONE;
                    push_mirrors(phase == mer_pkg::PH_DONE);
                end
                mer_pkg::PH_DONE: push_empty(1'b1);
                default: push_empty(1'b0);
            endcase
        endfunction

        function void check_result(logic signed [mer_pkg::OUT_BITS-1:0] x,
                                   logic signed [mer_pkg::OUT_BITS-1:0] y,
                                   logic has_point, logic last, logic done);
            t_mirror_result want;
            if (expected_points.size() == 0) begin
                $error("unexpected result: point_x=%0d point_y=%0d has_point=%0b",
                       x, y, has_point);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (x !== want.x) begin
                $error("point_x: expected %0d, got %0d", want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $error("point_y: expected %0d, got %0d", want.y, y);
                errors++;
            end
            if (has_point !== want.has_point) begin
                $error("has_point: expected %0b, got %0b", want.has_point, has_point);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_step: expected %0b, got %0b", want.last, last);
                errors++;
            end
            if (done !== want.done) begin
                $error("ellipse_done: expected %0b, got %0b", want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic                                i_cmd;
    logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_a;
    logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_b;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [mer_pkg::OUT_BITS-1:0] o_point_x;
    logic signed [mer_pkg::OUT_BITS-1:0] o_point_y;
    logic                                o_has_point;
    logic                                o_last_of_step;
    logic                                o_ellipse_done;

    arc_scoreboard arc_check;
    int unsigned   items_sent    = 0;
    int unsigned   cycle_count   = 0;
    int unsigned   in_stall_pct  = 0;   // only touched by the stimulus process
    int unsigned   out_stall_pct = 0;   // written with <=, read by the ready process
    int unsigned   ready_hold    = 0;

    midpoint_ellipse_rasterizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_semi_axis_a  (i_semi_axis_a),
        .i_semi_axis_b  (i_semi_axis_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_has_point    (o_has_point),
        .o_last_of_step (o_last_of_step),
        .o_ellipse_done (o_ellipse_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs or never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("midpoint_ellipse_rasterizer verification failed");
            $finish;
        end
    end

    // Receiver backpressure: random low bursts on i_ready.
    // ready_hold counts the remaining cycles of the current burst.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
            ready_hold <= $urandom_range(11, 1) - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Output monitor: every transfer on the result side is checked in order.
    // Values are the pre-edge ones, so the DUT's own updates at this edge
    // do not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            arc_check.check_result(o_point_x, o_point_y, o_has_point,
                                   o_last_of_step, o_ellipse_done);
    end

    // Offer one item and hold it until the transfer happens. An optional
    // idle burst drops valid first; otherwise valid stays high straight into
    // the next item. The prediction is updated at the accepting edge.
    task automatic push_command(input logic cmd,
                                input logic [mer_pkg::AXIS_BITS-1:0] a,
                                input logic [mer_pkg::AXIS_BITS-1:0] b);
        if (in_stall_pct != 0 && $urandom_range(99) < in_stall_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_semi_axis_a <= a;
        i_semi_axis_b <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        arc_check.note_input(cmd, a, b);
        items_sent++;
    endtask

    // Hold off the sender until every owed point has been transferred.
    // Waits on the clock before its first check, so valid is never lowered and raised
    // in the same time step.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (arc_check.pending() != 0);
    endtask

    // Start an ellipse, then advance until the arc closes plus 0..2 advances
    // past the end, or until max_steps advances (a new start cuts it short).
    task automatic trace_ellipse(input logic [mer_pkg::AXIS_BITS-1:0] a,
                                 input logic [mer_pkg::AXIS_BITS-1:0] b,
                                 input int unsigned max_steps);
        int unsigned steps;
        int unsigned extra;
        steps = 0;
        extra = $urandom_range(2);
        push_command(mer_pkg::CMD_START, a, b);
        while (steps < max_steps && !(arc_check.arc_closed() && extra == 0)) begin
            if (arc_check.arc_closed())
                extra--;
            // axes are don't-care on an advance; randomize them anyway
            push_command(mer_pkg::CMD_ADVANCE, mer_pkg::AXIS_BITS'($urandom),
                         mer_pkg::AXIS_BITS'($urandom));
            steps++;
        end
    endtask

    initial begin
        int unsigned random_end;
        int unsigned shape;
        int unsigned max_steps;
        arc_check = new();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= mer_pkg::CMD_START;
        i_semi_axis_a <= '0;
        i_semi_axis_b <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_stall_pct  = 20;
        out_stall_pct <= 20;

        // ---- directed ----
        // advance with no ellipse loaded
        push_command(mer_pkg::CMD_ADVANCE, '0, '0);
        // zero axes act as a unit circle; trace to the end and one to three past it
        trace_ellipse('0, '0, 10);
        push_command(mer_pkg::CMD_ADVANCE, '0, '0);
        // largest axes and the extreme aspect ratios, each cut by a restart
        trace_ellipse('1, '1, 3);
        trace_ellipse('1, 10'd1, 2);
        trace_ellipse(10'd1, '1, 2);
        // alternating bit patterns on both axes
        trace_ellipse(10'h2AA, 10'h155, 1);
        trace_ellipse(10'h155, 10'h2AA, 1);
        wait_for_results();

        // ---- random ----
        // Mostly complete traces of small ellipses; flat shapes reach the
        // region 1 floor, tall ones run long in region 2. Large axes and
        // loose noise items only get a few steps.
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            if (items_sent + QUIET_TAIL >= random_end) begin
                in_stall_pct  = 0;
                out_stall_pct <= 0;
            end else if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: in_stall_pct = 0;
                    1: in_stall_pct = 10;
                    2: in_stall_pct = 30;
                    default: in_stall_pct = 60;
                endcase
                case ($urandom_range(3))
                    0: out_stall_pct <= 0;
                    1: out_stall_pct <= 10;
                    2: out_stall_pct <= 30;
                    default: out_stall_pct <= 60;
                endcase
            end
            max_steps = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : 400;
            shape = $urandom_range(11);
            if (shape <= 6)
                trace_ellipse(mer_pkg::AXIS_BITS'($urandom_range(20, 1)),
                              mer_pkg::AXIS_BITS'($urandom_range(20, 1)), max_steps);
            else if (shape == 7)
                trace_ellipse(mer_pkg::AXIS_BITS'($urandom_range(48, 20)),
                              mer_pkg::AXIS_BITS'($urandom_range(3, 1)), max_steps);
            else if (shape == 8)
                trace_ellipse(mer_pkg::AXIS_BITS'($urandom_range(3, 1)),
                              mer_pkg::AXIS_BITS'($urandom_range(48, 20)), max_steps);
            else if (shape == 9)
                trace_ellipse(mer_pkg::AXIS_BITS'($urandom_range(32)),
                              mer_pkg::AXIS_BITS'($urandom_range(32)), max_steps);
            else if (shape == 10)
                trace_ellipse(mer_pkg::AXIS_BITS'($urandom), mer_pkg::AXIS_BITS'($urandom),
                              $urandom_range(6, 1));
            else
                repeat ($urandom_range(4, 1))
                    push_command(1'($urandom_range(1)), mer_pkg::AXIS_BITS'($urandom),
                                 mer_pkg::AXIS_BITS'($urandom));
            // no sender pauses in the quiet tail
            if (items_sent + QUIET_TAIL < random_end && $urandom_range(9) == 0)
                wait_for_results();
        end

        // ---- wind-down ----
        // Everything owed must arrive; then watch for stray transfers.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (arc_check.errors == 0 && arc_check.pending() == 0)
            $display("midpoint_ellipse_rasterizer verification clean");
        else
            $display("midpoint_ellipse_rasterizer verification failed");
        $finish;
    end

endmodule

### files.f
design/mer_pkg.sv
design/mer_ctrl.sv
design/mer_datapath.sv
design/midpoint_ellipse_rasterizer.sv
verif/midpoint_ellipse_rasterizer_tb.sv
